// File: rtl/core/shamh_pkg.sv
package shamh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
		logic       end_only;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_t;

	// One message word on its way from the packer to the compression core.
	typedef struct packed {
		logic [31:0] word;
		logic        blk_end;
		logic        msg_end;
	} qword_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [31:0] INIT_H [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
		return (v >> k) | (v << (32 - k));
	endfunction

endpackage

// File: rtl/core/sha256_message_hasher.sv
// Channel   Handshake     Payload                                  Word
// item      push / full   data_byte, final_byte, end_only          one message byte or end
// result    empty / pop   digest_word, word_index, last_word       one digest word
//
// A data byte is taken while the packer is idle and the word queue has room.
// For each 64-byte block the compression core does one load, 64 rounds and one update.
// Rounds 0 to 15 also wait on the word queue whenever it runs empty.
// At message end the packer emits pad and length bytes, up to 72, one per cycle while the
// word queue has room, and input stays stalled until the last length byte is out.
// The eight digest words then wait on the result side until popped.
// Reset leaves the initial hash loaded and both sides idle.
module sha256_message_hasher #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  shamh_pkg::in_t      item,
	output logic                empty,
	input  logic                pop,
	output shamh_pkg::out_t     result
);

	shamh_pkg::qword_t               f_word;
	shamh_pkg::qword_t               b_word;
	logic                            f_push;
	logic                            q_full;
	logic                            q_empty;
	logic                            q_pop;
	logic [$clog2(FIFO_DEPTH+1)-1:0] q_count;

	shamh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (f_push),
		.q_word (f_word)
	);

	shamh_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_word),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (b_word),
		.q_empty (q_empty),
		.count   (q_count)
	);

	shamh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_word  (b_word),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH))
		else $error("word queue count out of range");

	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.end_only) |=> full)
		else $error("input taken during padding");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.last_word) |=> empty)
		else $error("digest continues past last word");

	a_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> full)
		else $error("input open with full word queue");

endmodule

// File: rtl/core/shamh_front.sv
module shamh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  shamh_pkg::in_t       item,
	input  logic                 q_full,
	output logic                 q_push,
	output shamh_pkg::qword_t    q_word
);

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_PAD80 = 4'b0010,
		F_ZERO  = 4'b0100,
		F_LEN   = 4'b1000
	} fstate_t;

	fstate_t     state_q;
	logic [60:0] byte_cnt_q;
	logic [5:0]  blk_pos_q;
	logic [23:0] acc_q;
	logic [2:0]  len_idx_q;
	logic        accept;
	logic        emit;
	logic [7:0]  emit_byte;
	logic [63:0] bit_len;

	assign full = !(state_q == F_IDLE && !q_full);
	assign accept = push && !full;
	assign bit_len = {byte_cnt_q, 3'b000};

	always_comb begin
		emit = 1'b0;
		emit_byte = '0;
		unique case (state_q)
			F_IDLE: begin
				emit = accept && !item.end_only;
				emit_byte = item.data_byte;
			end
			F_PAD80: begin
				emit = !q_full;
				emit_byte = shamh_pkg::PAD_BYTE;
			end
			F_ZERO: begin
				emit = !q_full;
			end
			F_LEN: begin
				emit = !q_full;
				emit_byte = bit_len[6'(7 - len_idx_q) * 8 +: 8];
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign q_push = emit && (blk_pos_q[1:0] == 2'b11);
	assign q_word.word = {acc_q, emit_byte};
	assign q_word.blk_end = (blk_pos_q == 6'd63);
	assign q_word.msg_end = (state_q == F_LEN) && (len_idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			byte_cnt_q <= '0;
			blk_pos_q <= '0;
			len_idx_q <= '0;
		end else begin
			if (emit) begin
				blk_pos_q <= blk_pos_q + 6'd1;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (!item.end_only) begin
							byte_cnt_q <= byte_cnt_q + 61'd1;
						end
						if (item.end_only || item.final_byte) begin
							state_q <= F_PAD80;
						end
					end
				end
				F_PAD80: begin
					if (emit) begin
						state_q <= (blk_pos_q + 6'd1 == shamh_pkg::LEN_POS) ? F_LEN : F_ZERO;
					end
				end
				F_ZERO: begin
					if (emit && blk_pos_q + 6'd1 == shamh_pkg::LEN_POS) begin
						state_q <= F_LEN;
					end
				end
				F_LEN: begin
					if (emit) begin
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == 3'd7) begin
							state_q <= F_IDLE;
							byte_cnt_q <= '0;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			acc_q <= {acc_q[15:0], emit_byte};
		end
	end

endmodule

// File: rtl/core/shamh_fifo.sv
module shamh_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  shamh_pkg::qword_t           wr_data,
	output logic                        q_full,
	input  logic                        rd_en,
	output shamh_pkg::qword_t           rd_data,
	output logic                        q_empty,
	output logic [$clog2(DEPTH+1)-1:0]  count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	shamh_pkg::qword_t mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: rtl/core/shamh_back.sv
module shamh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  shamh_pkg::qword_t    q_word,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output shamh_pkg::out_t      result
);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_ROUND = 4'b0010,
		B_ADD   = 4'b0100,
		B_EMIT  = 4'b1000
	} bstate_t;

	bstate_t     state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        msg_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] wt;
	logic [31:0] sg0;
	logic [31:0] sg1;
	logic [31:0] s1;
	logic [31:0] s0;
	logic [31:0] chv;
	logic [31:0] mj;
	logic [31:0] tmp1;
	logic [31:0] tmp2;
	logic        early;
	logic        step;
	logic        out_pop;

	assign early = (rnd_q < 6'd16);
	assign q_pop = (state_q == B_ROUND) && early && !q_empty;
	assign step = (state_q == B_ROUND) && (!early || !q_empty);

	always_comb begin
		sg0 = shamh_pkg::rotr(w_q[1], 7) ^ shamh_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sg1 = shamh_pkg::rotr(w_q[14], 17) ^ shamh_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wt = early ? q_word.word : w_q[0] + sg0 + w_q[9] + sg1;
		s1 = shamh_pkg::rotr(v_q[4], 6) ^ shamh_pkg::rotr(v_q[4], 11)
			^ shamh_pkg::rotr(v_q[4], 25);
		chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		tmp1 = v_q[7] + s1 + chv + shamh_pkg::ROUND_K[rnd_q] + wt;
		s0 = shamh_pkg::rotr(v_q[0], 2) ^ shamh_pkg::rotr(v_q[0], 13)
			^ shamh_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		tmp2 = s0 + mj;
	end

	assign empty = (state_q != B_EMIT);
	assign out_pop = pop && !empty;
	assign result.digest_word = h_q[idx_q];
	assign result.word_index = idx_q;
	assign result.last_word = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			msg_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shamh_pkg::INIT_H[i];
			end
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_ROUND;
						rnd_q <= '0;
					end
				end
				B_ROUND: begin
					if (step) begin
						rnd_q <= rnd_q + 6'd1;
						if (q_pop && rnd_q == 6'd15) begin
							msg_q <= q_word.msg_end;
						end
						if (rnd_q == 6'd63) begin
							state_q <= B_ADD;
						end
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					idx_q <= '0;
					state_q <= msg_q ? B_EMIT : B_IDLE;
				end
				B_EMIT: begin
					if (out_pop) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= B_IDLE;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= shamh_pkg::INIT_H[i];
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (step) begin
			v_q[0] <= tmp1 + tmp2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + tmp1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wt;
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [7:0]  data_byte;
		logic        final_byte;
		logic        end_only;
		logic        has_digest;
		logic [31:0] digest0;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	shamh_pkg::in_t  item;
	logic empty;
	logic pop;
	shamh_pkg::out_t result;

	logic [31:0] hash_state [0:7];
	logic [7:0]  block_buf [0:63];
	logic [60:0] msg_bytes;
	shamh_pkg::out_t digest_queue [$];
	logic [31:0] typed_digest0 [$];

	int   errors;
	int   idle_cycles;
	logic hold_off;
	logic pause_long;

	sha256_message_hasher u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] ror(input logic [31:0] v, input int k);
		return (v >> k) | (v << (32 - k));
	endfunction

	task automatic compress_buf();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + shamh_pkg::ROUND_K[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic hash_predict(input shamh_pkg::in_t w);
		int pos;
		logic [63:0] bits;
		shamh_pkg::out_t o;
		if (!w.end_only) begin
			pos = int'(msg_bytes[5:0]);
			block_buf[pos] = w.data_byte;
			msg_bytes = msg_bytes + 61'd1;
			if (pos == 63) compress_buf();
			if (!w.final_byte) return;
		end
		pos = int'(msg_bytes[5:0]);
		block_buf[pos] = shamh_pkg::PAD_BYTE;
		for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
		if (pos >= 56) begin
			compress_buf();
			for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
		end
		bits = {msg_bytes, 3'b000};
		for (int i = 0; i < 8; i++) block_buf[63-i] = bits[8*i +: 8];
		compress_buf();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hash_state[i];
			o.word_index = 3'(i);
			o.last_word = (i == 7);
			digest_queue.insert(digest_queue.size(), o);
		end
		for (int i = 0; i < 8; i++) hash_state[i] = shamh_pkg::INIT_H[i];
		msg_bytes = '0;
	endtask

	always @(posedge clk) begin
		shamh_pkg::out_t ex;
		if (arst_n && push && !full) hash_predict(item);
		if (arst_n && pop && !empty) begin
			if (digest_queue.size() == 0) begin
				$error("digest word with nothing expected: %h", result.digest_word);
				errors++;
			end else begin
				ex = digest_queue.pop_front();
				if (ex.word_index == 0 && typed_digest0.size() > 0) begin
					if (typed_digest0[0] !== 32'h0 &&
						typed_digest0[0] !== result.digest_word) begin
						$error("digest_word typed: expected %h actual %h",
							typed_digest0[0], result.digest_word);
						errors++;
					end
					void'(typed_digest0.pop_front());
				end
				if (result.digest_word !== ex.digest_word) begin
					$error("digest_word: expected %h actual %h", ex.digest_word,
						result.digest_word);
					errors++;
				end
				if (result.word_index !== ex.word_index) begin
					$error("word_index: expected %0d actual %0d", ex.word_index,
						result.word_index);
					errors++;
				end
				if (result.last_word !== ex.last_word) begin
					$error("last_word: expected %0d actual %0d", ex.last_word,
						result.last_word);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int pat;
		pop = 1'b0;
		pat = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			pat++;
			if (pat % 200 < 60) pop <= 1'b1;
			else pop <= ($urandom_range(0, 3) != 0) && (pat % 7 != 3);
		end
	end

	task automatic send(input shamh_pkg::in_t w);
		item <= w;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic gap();
		if ($urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin
		dir_row_t rows [9] = '{
			'{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
			'{8'hff, 1'b1, 1'b1, 1'b1, 32'he3b0c442},
			'{8'h61, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h62, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h63, 1'b1, 1'b0, 1'b1, 32'hba7816bf},
			'{8'h00, 1'b1, 1'b0, 1'b1, 32'h6e340b9c},
			'{8'hff, 1'b1, 1'b0, 1'b1, 32'h0},
			'{8'haa, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h55, 1'b0, 1'b1, 1'b1, 32'h0}
		};
		dir_row_t r;
		shamh_pkg::in_t w;
		int len;
		int msgs;
		errors = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		for (int i = 0; i < 8; i++) hash_state[i] = shamh_pkg::INIT_H[i];
		msg_bytes = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, end-only with final set, "abc", one-byte extremes, a byte closed by end-only.
		foreach (rows[i]) begin
			r = rows[i];
			if (r.has_digest) typed_digest0.insert(typed_digest0.size(), r.digest0);
			w.data_byte = r.data_byte;
			w.final_byte = r.final_byte;
			w.end_only = r.end_only;
			send(w);
			gap();
		end

		// A 56-byte message pushes the length into a second padding block.
		len = 56;
		for (int i = 0; i < len; i++) begin
			w.data_byte = 8'($urandom);
			w.final_byte = (i == len - 1);
			w.end_only = 1'b0;
			send(w);
		end

		push <= 1'b0;
		@(posedge clk);
		hold_off = 1'b1;
		for (int i = 0; i < 20; i++) begin
			w.data_byte = 8'($urandom);
			w.final_byte = (i % 3 == 2);
			w.end_only = 1'b0;
			send(w);
		end
		push <= 1'b0;
		while (digest_queue.size() != 0) @(posedge clk);

		msgs = 0;
		while (msgs < 12) begin
			len = $urandom_range(0, 7);
			for (int i = 0; i < len; i++) begin
				w.data_byte = 8'($urandom);
				w.final_byte = (i == len - 1) ? 1'b1 : 1'b0;
				w.end_only = 1'b0;
				send(w);
				if (msgs % 5 != 4) gap();
			end
			if (len == 0 || $urandom_range(0, 5) == 0) begin
				w.data_byte = 8'($urandom);
				w.final_byte = 1'($urandom);
				w.end_only = 1'b1;
				send(w);
			end
			msgs++;
			if (msgs % 5 != 4) gap();
		end
		push <= 1'b0;

		while (digest_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
